FILE: sv/ssh_packet_deframer_top_defines.svh
// Assertion macros for the SSH packet deframer.
// Included by the top level; needs no other file.
`ifndef SSH_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define SSH_PACKET_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define SSHDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSHDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sshdf_pkg.sv
// Types and constants shared by the SSH packet deframer modules.
// No dependencies.
`default_nettype none

package sshdf_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [1:0] ERR_LENGTH   = 2'd0;
	localparam logic [1:0] ERR_SEQUENCE = 2'd1;
	localparam logic [1:0] ERR_PADDING  = 2'd2;

	localparam logic [2:0] HDR_PAD  = 3'd4;
	localparam logic [2:0] HDR_BODY = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       first_of_payload;
		logic       packet_end;
		logic [1:0] error_code;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/sshdf_core.sv
// Deframer state and per-byte next-state and result logic.
// Depends on sshdf_pkg.
`default_nettype none

module sshdf_core #(
	parameter int MAX_PACKET_BYTES = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [31:0]      sequence_limit,
	output logic                  res_valid,
	output sshdf_pkg::result_t    res
);
	import sshdf_pkg::*;

	localparam int PLW = $clog2(MAX_PACKET_BYTES);
	localparam logic [31:0] LEN_MAX = 32'(MAX_PACKET_BYTES - 4);

	logic [2:0]     hdr_q, hdr_n;
	logic [31:0]    len_q, len_n;
	logic [7:0]     pad_q, pad_n;
	logic [PLW-1:0] pl_q, pl_n;
	logic           first_q, first_n;
	logic [31:0]    seq_q, seq_n;
	logic           halted_q, halted_n;
	logic           finish;
	logic [31:0]    pl_calc;

	assign pl_calc = len_q - 32'd1 - {24'd0, rx_byte};

	always_comb begin
		hdr_n = hdr_q;
		len_n = len_q;
		pad_n = pad_q;
		pl_n = pl_q;
		first_n = first_q;
		seq_n = seq_q;
		halted_n = halted_q;
		finish = 1'b0;
		res_valid = 1'b0;
		res = '0;
		if (!halted_q) begin
			if (hdr_q < HDR_PAD) begin
				len_n = {len_q[23:0], rx_byte};
				hdr_n = hdr_q + 3'd1;
				if (hdr_q == HDR_PAD - 3'd1 && (len_n == 32'd0 || len_n > LEN_MAX)) begin
					halted_n = 1'b1;
					res_valid = 1'b1;
					res.kind = KIND_ERROR;
					res.error_code = ERR_LENGTH;
				end
			end else if (hdr_q == HDR_PAD) begin
				if (seq_q >= sequence_limit) begin
					halted_n = 1'b1;
					res_valid = 1'b1;
					res.kind = KIND_ERROR;
					res.error_code = ERR_SEQUENCE;
				end else if ({24'd0, rx_byte} >= len_q) begin
					halted_n = 1'b1;
					res_valid = 1'b1;
					res.kind = KIND_ERROR;
					res.error_code = ERR_PADDING;
				end else begin
					pad_n = rx_byte;
					pl_n = pl_calc[PLW-1:0];
					first_n = 1'b1;
					hdr_n = HDR_BODY;
					if (pl_calc == 32'd0 && rx_byte == 8'd0) begin
						finish = 1'b1;
						res_valid = 1'b1;
						res.kind = KIND_END;
						res.packet_end = 1'b1;
					end
				end
			end else if (pl_q != '0) begin
				pl_n = pl_q - PLW'(1);
				first_n = 1'b0;
				res_valid = 1'b1;
				res.kind = KIND_PAYLOAD;
				res.data_byte = rx_byte;
				res.first_of_payload = first_q;
				if (pl_n == '0 && pad_q == 8'd0) begin
					finish = 1'b1;
					res.packet_end = 1'b1;
				end
			end else begin
				if (pad_q != 8'd0) begin
					pad_n = pad_q - 8'd1;
				end
				if (pad_n == 8'd0) begin
					finish = 1'b1;
					res_valid = 1'b1;
					res.kind = KIND_END;
					res.packet_end = 1'b1;
				end
			end
		end
		if (finish) begin
			seq_n = seq_q + 32'd1;
			hdr_n = 3'd0;
			len_n = 32'd0;
			pad_n = 8'd0;
			pl_n = '0;
			first_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= 3'd0;
			len_q <= 32'd0;
			pad_q <= 8'd0;
			pl_q <= '0;
			first_q <= 1'b0;
			seq_q <= 32'd0;
			halted_q <= 1'b0;
		end else if (step) begin
			hdr_q <= hdr_n;
			len_q <= len_n;
			pad_q <= pad_n;
			pl_q <= pl_n;
			first_q <= first_n;
			seq_q <= seq_n;
			halted_q <= halted_n;
		end
	end

endmodule

`default_nettype wire

FILE: sv/ssh_packet_deframer_top.sv
// Channel    Direction  Handshake            Payload
// input      in         in_valid / in_stall  rx_byte
// result     out        out_valid / out_stall kind, data_byte, first_of_payload,
//                                            packet_end, error_code
// config     in         cfg_valid / cfg_ready sequence_limit
//
// One byte per cycle sustained when out_stall is low; a result is registered, not combinational.
// The input register feeds the header/body logic in sshdf_core, which loads the result register.
// Reset clears all counters, the sequence number and the halt flag; the limit resets to all ones.
// A stalled result register holds a full input register, which then stalls the input side.
// Top level of the SSH packet deframer; depends on sshdf_pkg, sshdf_core and the defines header.
`default_nettype none

`include "ssh_packet_deframer_top_defines.svh"

module ssh_packet_deframer_top #(
	parameter int MAX_PACKET_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic             first_of_payload,
	output logic             packet_end,
	output logic [1:0]       error_code,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] sequence_limit
);
	import sshdf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     out_q;
	logic [31:0] limit_q;
	logic        advance;
	logic        step;
	logic        res_valid;
	result_t     res;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= sequence_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= step && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= rx_byte;
		end
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	sshdf_core #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(byte_s1),
		.sequence_limit(limit_q),
		.res_valid(res_valid),
		.res(res)
	);

	assign out_valid = out_valid_q;
	assign kind = out_q.kind;
	assign data_byte = out_q.data_byte;
	assign first_of_payload = out_q.first_of_payload;
	assign packet_end = out_q.packet_end;
	assign error_code = out_q.error_code;

	`SSHDF_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stall without blocked result")
	`SSHDF_ASSERT_NEXT(a_halt_silent, clk, arst_n, out_valid && !out_stall && kind == KIND_ERROR, !out_valid, "result after error")
	`SSHDF_ASSERT_IMPL(a_error_shape, clk, arst_n, out_valid && kind == KIND_ERROR, !packet_end && !first_of_payload && data_byte == 8'd0, "malformed error result")
	`SSHDF_ASSERT_IMPL(a_end_shape, clk, arst_n, out_valid && kind == KIND_END, packet_end && data_byte == 8'd0 && error_code == ERR_LENGTH, "malformed end result")

endmodule

`default_nettype wire
